>>> rtl/jse_pkg.sv
// Package for the JSON string escaper: character codes, widths and the case-mode codes.
`default_nettype none
package jse_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned MaxOut   = 8;
	localparam int unsigned MaxBody  = 6;
	localparam int unsigned OutCntW  = $clog2(MaxOut + 1);
	localparam int unsigned OutIdxW  = $clog2(MaxOut);
	localparam int unsigned BodyCntW = $clog2(MaxBody + 1);

	localparam logic [ByteW-1:0] ChQuote     = 8'h22;
	localparam logic [ByteW-1:0] ChBackslash = 8'h5c;
	localparam logic [ByteW-1:0] ChSpace     = 8'h20;
	localparam logic [ByteW-1:0] ChDel       = 8'h7f;
	localparam logic [ByteW-1:0] ChZero      = 8'h30;
	localparam logic [ByteW-1:0] ChOne       = 8'h31;
	localparam logic [ByteW-1:0] ChLowerA    = 8'h61;
	localparam logic [ByteW-1:0] ChLowerZ    = 8'h7a;
	localparam logic [ByteW-1:0] ChUpperA    = 8'h41;
	localparam logic [ByteW-1:0] ChUpperZ    = 8'h5a;
	localparam logic [ByteW-1:0] ChB         = 8'h62;
	localparam logic [ByteW-1:0] ChT         = 8'h74;
	localparam logic [ByteW-1:0] ChN         = 8'h6e;
	localparam logic [ByteW-1:0] ChF         = 8'h66;
	localparam logic [ByteW-1:0] ChR         = 8'h72;
	localparam logic [ByteW-1:0] ChU         = 8'h75;
	localparam logic [ByteW-1:0] ChCaseDiff  = 8'h20;

	localparam logic [ByteW-1:0] CtlBackspace = 8'h08;
	localparam logic [ByteW-1:0] CtlTab       = 8'h09;
	localparam logic [ByteW-1:0] CtlNewline   = 8'h0a;
	localparam logic [ByteW-1:0] CtlFormFeed  = 8'h0c;
	localparam logic [ByteW-1:0] CtlReturn    = 8'h0d;

	typedef enum logic [1:0] {
		CASE_KEEP  = 2'd0,
		CASE_UPPER = 2'd1,
		CASE_LOWER = 2'd2,
		CASE_RSVD  = 2'd3
	} case_mode_t;

	typedef logic [ByteW-1:0] byte_t;

	// Lowercase hex digit for one nibble.
	function automatic byte_t hex_digit(input logic [3:0] nib);
		byte_t d;
		if (nib < 4'd10) begin
			d = ChZero + {4'd0, nib};
		end else begin
			d = ChLowerA + {4'd0, nib} - 8'd10;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> rtl/json_string_escaper_unit.sv
// JSON string escaper: quotes and escapes a byte stream, one output byte per cycle unless stalled.
//
// One input byte is accepted per transfer and expanded in a single pass into up to eight
// output bytes held in a result buffer, which drains on the master side one byte per clock
// while m_tready is high, so plain text streams at one byte per clock when not stalled. A
// short escape gives two output bytes and a \u00xx escape six, plus one for each quote.
// The next input transfer is taken in the same cycle as the last output byte of the previous
// item. Bytes that are dropped (after a zero byte or between strings) give no output but the
// quotes that their flags ask for, and otherwise leave the buffer empty.
// m_tlast marks the last output byte caused by one input byte.
`default_nettype none
module json_string_escaper_unit
	import jse_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [ByteW-1:0] s_tdata,  // [7:0] data_byte
	input  wire logic             s_tlast,  // last_of_string
	input  wire logic [2:0]       s_tuser,  // [0] first_of_string, [2:1] case_mode
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [ByteW-1:0]      m_tdata,  // [7:0] out_byte
	output logic                  m_tlast   // last_of_run
);

	logic                string_ended_q;
	logic                valid_s1;
	byte_t               buf_s1 [MaxOut];
	logic [OutCntW-1:0]  cnt_s1;
	logic [OutIdxW-1:0]  idx_q;

	logic                in_xfer;
	logic                out_xfer;
	logic                first_in;
	case_mode_t          mode_in;
	byte_t               c_in;
	byte_t               mapped;
	byte_t               body [MaxBody];
	logic [BodyCntW-1:0] body_cnt;
	logic                ended_after_first;
	logic                emit_body;
	logic                ended_next;
	byte_t               exp_bytes [MaxOut];
	logic [OutCntW-1:0]  exp_cnt;
	logic                run_end;

	assign c_in     = s_tdata;
	assign first_in = s_tuser[0];
	assign mode_in  = case_mode_t'(s_tuser[2:1]);

	assign run_end  = ({1'b0, idx_q} + OutCntW'(1)) == cnt_s1;
	assign m_tvalid = valid_s1;
	assign m_tdata  = buf_s1[idx_q];
	assign m_tlast  = run_end;
	assign out_xfer = m_tvalid && m_tready;
	assign s_tready = !valid_s1 || (m_tready && run_end);
	assign in_xfer  = s_tvalid && s_tready;

	always_comb begin
		mapped = c_in;
		case (mode_in)
			CASE_UPPER: begin
				if (c_in >= ChLowerA && c_in <= ChLowerZ) mapped = c_in - ChCaseDiff;
			end
			CASE_LOWER: begin
				if (c_in >= ChUpperA && c_in <= ChUpperZ) mapped = c_in + ChCaseDiff;
			end
			default: mapped = c_in;
		endcase
	end

	// Escape of the byte itself, without the quotes.
	always_comb begin
		for (int i = 0; i < MaxBody; i++) body[i] = ChZero;
		body_cnt = BodyCntW'(1);
		body[0]  = ChBackslash;
		if (c_in == ChQuote || c_in == ChBackslash) begin
			body[1]  = c_in;
			body_cnt = BodyCntW'(2);
		end else if (c_in >= ChSpace) begin
			body[0] = (c_in <= ChDel) ? mapped : c_in;
		end else begin
			body_cnt = BodyCntW'(2);
			case (c_in)
				CtlBackspace: body[1] = ChB;
				CtlTab:       body[1] = ChT;
				CtlNewline:   body[1] = ChN;
				CtlFormFeed:  body[1] = ChF;
				CtlReturn:    body[1] = ChR;
				default: begin
					body[1]  = ChU;
					body[2]  = ChZero;
					body[3]  = ChZero;
					body[4]  = c_in[4] ? ChOne : ChZero;
					body[5]  = hex_digit(c_in[3:0]);
					body_cnt = BodyCntW'(MaxBody);
				end
			endcase
		end
	end

	assign ended_after_first = first_in ? 1'b0 : string_ended_q;
	assign emit_body         = !ended_after_first && (c_in != '0);
	assign ended_next        = s_tlast || ended_after_first || (c_in == '0);

	// Place opening quote, escape and closing quote into consecutive slots.
	always_comb begin
		logic [BodyCntW-1:0] used;
		logic [OutCntW-1:0]  rel;
		used = emit_body ? body_cnt : '0;
		for (int k = 0; k < MaxOut; k++) begin
			exp_bytes[k] = ChQuote;
			rel = OutCntW'(k) - OutCntW'(first_in);
			if (!(first_in && k == 0) && rel < OutCntW'(used)) begin
				exp_bytes[k] = body[rel[2:0]];
			end
		end
		exp_cnt = OutCntW'(first_in) + OutCntW'(used) + OutCntW'(s_tlast);
	end

	// An input transfer only happens with the buffer empty or on its last output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_ended_q <= 1'b0;
			valid_s1       <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (in_xfer) begin
				string_ended_q <= ended_next;
				valid_s1       <= (exp_cnt != '0);
				idx_q          <= '0;
			end else if (out_xfer) begin
				if (run_end) begin
					valid_s1 <= 1'b0;
				end else begin
					idx_q <= idx_q + OutIdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			buf_s1 <= exp_bytes;
			cnt_s1 <= exp_cnt;
		end
	end

endmodule
`default_nettype wire
